[design/sn3d_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Simplex noise 3D package
// Shared constants, tables and helper functions for the noise pipeline.
// ----------------------------------------------------------------------------
package sn3d_pkg;

	// 0.6 in Q.32.
	localparam logic [31:0] CORNER_LIMIT = 32'd2576980378;

	// Fixed permutation table for corner hashing.
	function automatic logic [7:0] perm(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
		8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
		8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
		8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
		8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
		8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,
		8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
		8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,
		8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,
		8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,
		8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,
		8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,
		8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,
		8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
		8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,
		8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,
		8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,
		8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,
		8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,
		8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,
		8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180};
		return t[a];
	endfunction

	// Gradient index from a hash value modulo 12 (by repeated subtraction).
	function automatic logic [3:0] mod12(input logic [7:0] h);
		logic [8:0] r;
		r = {1'b0, h};
		if (r >= 9'd192) r = r - 9'd192;
		if (r >= 9'd96) r = r - 9'd96;
		if (r >= 9'd48) r = r - 9'd48;
		if (r >= 9'd24) r = r - 9'd24;
		if (r >= 9'd12) r = r - 9'd12;
		return r[3:0];
	endfunction

	// Gradient dot product with a Q.16 offset vector.
	function automatic logic signed [19:0] grad_dot(input logic [3:0] g,
			input logic signed [17:0] x, input logic signed [17:0] y,
			input logic signed [17:0] z);
		logic signed [19:0] a, b, c;
		a = 20'(x);
		b = 20'(y);
		c = 20'(z);
		unique case (g)
			4'd0: return a + b;
			4'd1: return b - a;
			4'd2: return a - b;
			4'd3: return -a - b;
			4'd4: return a + c;
			4'd5: return c - a;
			4'd6: return a - c;
			4'd7: return -a - c;
			4'd8: return b + c;
			4'd9: return c - b;
			4'd10: return b - c;
			4'd11: return -b - c;
			default: return '0;
		endcase
	endfunction

endpackage
`default_nettype wire

[design/simplex_noise_3d_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Simplex noise 3D core
// Fully pipelined 3D simplex noise on fixed-point coordinates.
// ----------------------------------------------------------------------------
// Usage: drive coord_x/y/z (signed, COORD_FRAC_BITS fraction bits) with start
// high. The request is taken at any edge, since busy is always low. One point
// enters every cycle. After acceptance the Q1.15 noise value appears on noise_value
// with done high for exactly one cycle. The pipeline holds three skew stages
// (scale and sum, cell divide, offsets), the tetrahedron choice, rounding and
// hashing, the five-stage corner unit (square, subtract, two 32x32 power
// multiplies, product), the sum of the four corners and the final scale and
// saturate.
// Throughput is one point per cycle. The receiver cannot stall, so the
// pipeline never waits. Reset clears only the valid bits, so no result is
// shown until a new request has passed through.
// ----------------------------------------------------------------------------
module simplex_noise_3d_core #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] coord_x,
	input  wire logic signed [31:0] coord_y,
	input  wire logic signed [31:0] coord_z,
	output logic                    done,
	output logic signed [15:0]      noise_value
);
	import sn3d_pkg::*;

	localparam int F = COORD_FRAC_BITS;
	localparam int LAT = 12;
	localparam logic signed [39:0] ONE = 40'sd1 <<< F;
	localparam logic signed [39:0] ONE_X2 = ONE * 40'sd2;
	localparam logic signed [39:0] ONE_X3 = ONE * 40'sd3;
	localparam logic signed [39:0] UNIT = ONE * 40'sd6;
	// Bias that keeps the reciprocal division on a positive operand.
	localparam logic signed [47:0] DIV_OFFSET = 48'sd33554432;
	localparam logic signed [47:0] DIV_BIAS = DIV_OFFSET * 48'sd6;

	logic [LAT-1:0] vld_q;
	logic accept;
	assign busy = 1'b0;
	assign accept = start && !busy;

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	// Stage 1: scaled coordinates and skew sum (units of 1/(6*2^F)).
	logic signed [39:0] sx_s1, sy_s1, sz_s1, sum2_s1;
	always_ff @(posedge clk) begin
		logic signed [39:0] s;
		s = 40'(coord_x) + 40'(coord_y) + 40'(coord_z);
		sx_s1 <= 40'(coord_x) * 40'sd6 + 40'sd2 * s;
		sy_s1 <= 40'(coord_y) * 40'sd6 + 40'sd2 * s;
		sz_s1 <= 40'(coord_z) * 40'sd6 + 40'sd2 * s;
		sum2_s1 <= 40'sd2 * s;
	end

	// Floor division by 6*2^F: shift by F, then divide by 6 via reciprocal.
	// The biased operand stays below 2^29, where the reciprocal is exact.
	function automatic logic signed [33:0] fdiv6(input logic signed [47:0] v);
		logic signed [47:0] w;
		logic [31:0] u;
		logic [63:0] p;
		logic [39:0] q;
		w = v >>> F;
		u = 32'(w + DIV_BIAS);
		p = 64'(u) * 64'd5726623062;
		q = 40'(p[63:35]);
		if (40'(u) - q * 40'd6 >= 40'd6) q = q + 40'd1;
		return 34'($signed(q) - 40'(DIV_OFFSET));
	endfunction

	// Stage 2: cell indices.
	logic signed [33:0] ci_s2, cj_s2, ck_s2;
	logic signed [39:0] sx_s2, sy_s2, sz_s2, sum2_s2;
	always_ff @(posedge clk) begin
		ci_s2 <= fdiv6(48'(sx_s1));
		cj_s2 <= fdiv6(48'(sy_s1));
		ck_s2 <= fdiv6(48'(sz_s1));
		sx_s2 <= sx_s1;
		sy_s2 <= sy_s1;
		sz_s2 <= sz_s1;
		sum2_s2 <= sum2_s1;
	end

	// Stage 3: exact offsets from the cell origin, with the skew sum removed.
	logic signed [39:0] ox_s3, oy_s3, oz_s3;
	logic [7:0] i_s3, j_s3, k_s3;
	always_ff @(posedge clk) begin
		logic signed [39:0] back;
		back = (40'(ci_s2) + 40'(cj_s2) + 40'(ck_s2)) * ONE;
		ox_s3 <= back + (sx_s2 - sum2_s2 - 40'(ci_s2) * UNIT);
		oy_s3 <= back + (sy_s2 - sum2_s2 - 40'(cj_s2) * UNIT);
		oz_s3 <= back + (sz_s2 - sum2_s2 - 40'(ck_s2) * UNIT);
		i_s3 <= ci_s2[7:0];
		j_s3 <= cj_s2[7:0];
		k_s3 <= ck_s2[7:0];
	end

	// Stage 4: tetrahedron choice and the exact offsets of all four corners.
	logic signed [39:0] v_s4 [4][3];
	logic [7:0]         idx_s4 [4][3];
	always_ff @(posedge clk) begin
		logic a1, b1, c1, a2, b2, c2;
		if (ox_s3 >= oy_s3) begin
			if (oy_s3 >= oz_s3) {a1,b1,c1,a2,b2,c2} = 6'b100110;
			else if (ox_s3 >= oz_s3) {a1,b1,c1,a2,b2,c2} = 6'b100101;
			else {a1,b1,c1,a2,b2,c2} = 6'b001101;
		end else begin
			if (oy_s3 < oz_s3) {a1,b1,c1,a2,b2,c2} = 6'b001011;
			else if (ox_s3 < oz_s3) {a1,b1,c1,a2,b2,c2} = 6'b010011;
			else {a1,b1,c1,a2,b2,c2} = 6'b010110;
		end
		v_s4[0][0] <= ox_s3;
		v_s4[0][1] <= oy_s3;
		v_s4[0][2] <= oz_s3;
		v_s4[1][0] <= ox_s3 - (a1 ? UNIT : 40'sd0) + ONE;
		v_s4[1][1] <= oy_s3 - (b1 ? UNIT : 40'sd0) + ONE;
		v_s4[1][2] <= oz_s3 - (c1 ? UNIT : 40'sd0) + ONE;
		v_s4[2][0] <= ox_s3 - (a2 ? UNIT : 40'sd0) + ONE_X2;
		v_s4[2][1] <= oy_s3 - (b2 ? UNIT : 40'sd0) + ONE_X2;
		v_s4[2][2] <= oz_s3 - (c2 ? UNIT : 40'sd0) + ONE_X2;
		v_s4[3][0] <= ox_s3 - UNIT + ONE_X3;
		v_s4[3][1] <= oy_s3 - UNIT + ONE_X3;
		v_s4[3][2] <= oz_s3 - UNIT + ONE_X3;
		idx_s4[0][0] <= i_s3;
		idx_s4[0][1] <= j_s3;
		idx_s4[0][2] <= k_s3;
		idx_s4[1][0] <= i_s3 + 8'(a1);
		idx_s4[1][1] <= j_s3 + 8'(b1);
		idx_s4[1][2] <= k_s3 + 8'(c1);
		idx_s4[2][0] <= i_s3 + 8'(a2);
		idx_s4[2][1] <= j_s3 + 8'(b2);
		idx_s4[2][2] <= k_s3 + 8'(c2);
		idx_s4[3][0] <= i_s3 + 8'd1;
		idx_s4[3][1] <= j_s3 + 8'd1;
		idx_s4[3][2] <= k_s3 + 8'd1;
	end

	// Offset to Q.16, nearest with ties upward: floor((v*2^17 + unit) / (2*unit)).
	function automatic logic signed [17:0] toq(input logic signed [39:0] v);
		logic signed [47:0] n;
		n = (48'(v) <<< 17) + 48'(UNIT);
		return 18'(fdiv6(n >>> 1));
	endfunction

	function automatic logic [3:0] hsh(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic [7:0] h;
		h = perm(c);
		h = perm(8'(b + h));
		h = perm(8'(a + h));
		return mod12(h);
	endfunction

	// Stage 5: rounding to Q.16 and corner hashing.
	logic signed [17:0] q_s5 [4][3];
	logic [3:0]         g_s5 [4];
	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			for (int d = 0; d < 3; d++) begin
				q_s5[c][d] <= toq(v_s4[c][d]);
			end
			g_s5[c] <= hsh(idx_s4[c][0], idx_s4[c][1], idx_s4[c][2]);
		end
	end

	// Stages 6 to 10: four corner units in parallel.
	logic signed [52:0] term [4];
	for (genvar c = 0; c < 4; c++) begin : g_corner
		sn3d_corner u_corner (
			.clk  (clk),
			.qx   (q_s5[c][0]),
			.qy   (q_s5[c][1]),
			.qz   (q_s5[c][2]),
			.grad (g_s5[c]),
			.term (term[c])
		);
	end

	// Stage 11: sum of contributions.
	logic signed [54:0] acc_s11;
	always_ff @(posedge clk) begin
		acc_s11 <= 55'(term[0]) + 55'(term[1]) + 55'(term[2]) + 55'(term[3]);
	end

	// Stage 12: scale, round and saturate.
	always_ff @(posedge clk) begin
		logic signed [54:0] v;
		v = (acc_s11 + 55'sd134217728) >>> 28;
		if (v > 55'sd32767) noise_value <= 16'sd32767;
		else if (v < -55'sd32767) noise_value <= -16'sd32767;
		else noise_value <= 16'(v);
	end

	assign done = vld_q[LAT-1];

endmodule
`default_nettype wire

[design/sn3d_corner.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Simplex noise corner term
// Pipelined (0.6 - r^2)^4 * dot(gradient, offset) for one corner.
// ----------------------------------------------------------------------------
module sn3d_corner (
	input  wire logic                clk,
	input  wire logic signed [17:0]  qx,
	input  wire logic signed [17:0]  qy,
	input  wire logic signed [17:0]  qz,
	input  wire logic [3:0]          grad,
	output logic signed [52:0]       term
);
	import sn3d_pkg::*;

	logic [35:0]        sq_x_s1, sq_y_s1, sq_z_s1;
	logic signed [19:0] dot_s1, dot_s2, dot_s3, dot_s4;
	logic [37:0]        r2;
	logic [31:0]        t_s2;
	logic               in_s2, in_s3, in_s4;
	logic [63:0]        tt;
	logic [31:0]        t2_s3, t4_s4;
	logic [63:0]        t2t2;

	// Squares of the offsets and the gradient dot product.
	always_ff @(posedge clk) begin
		sq_x_s1 <= 36'(qx * qx);
		sq_y_s1 <= 36'(qy * qy);
		sq_z_s1 <= 36'(qz * qz);
		dot_s1  <= grad_dot(grad, qx, qy, qz);
	end

	// Distance falloff t = 0.6 - r^2.
	assign r2 = 38'(sq_x_s1) + 38'(sq_y_s1) + 38'(sq_z_s1);
	always_ff @(posedge clk) begin
		in_s2  <= r2 < 38'(CORNER_LIMIT);
		t_s2   <= CORNER_LIMIT - r2[31:0];
		dot_s2 <= dot_s1;
	end

	// t squared, then t to the fourth.
	assign tt = 64'(t_s2) * 64'(t_s2);
	always_ff @(posedge clk) begin
		t2_s3  <= tt[63:32];
		in_s3  <= in_s2;
		dot_s3 <= dot_s2;
	end

	assign t2t2 = 64'(t2_s3) * 64'(t2_s3);
	always_ff @(posedge clk) begin
		t4_s4  <= t2t2[63:32];
		in_s4  <= in_s3;
		dot_s4 <= dot_s3;
	end

	// Contribution, zero outside the radius.
	always_ff @(posedge clk) begin
		term <= in_s4 ? 53'($signed({1'b0, t4_s4}) * dot_s4) : '0;
	end

endmodule
`default_nettype wire

[design/simplex_noise_3d_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Simplex noise 3D checker
// Port-level checks of request and result timing and of the result range.
// ----------------------------------------------------------------------------
module simplex_noise_3d_sva (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic signed [15:0] noise_value
);
	// Each result follows its request after a fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##12 done) else $error("missing result");
	a_no_spur: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 12)) else $error("spurious result");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> noise_value != -16'sd32768) else $error("result out of range");
endmodule

bind simplex_noise_3d_core simplex_noise_3d_sva u_sva (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .noise_value(noise_value)
);
`default_nettype wire
